@@ hdl/zlh_pkg.sv @@
package zlh_pkg;

    localparam int OffsetWidth = 48;

    localparam logic [31:0] LocalSig = 32'h0403_4b50;
    localparam logic [15:0] DescBit  = 16'h0008;
    localparam logic [7:0]  CharP    = 8'h50;
    localparam logic [7:0]  CharK    = 8'h4B;

    localparam logic [31:0] SkipMax   = 32'hFFFF_FFFF;
    localparam logic [15:0] RecordMax = 16'hFFFF;

    // header field numbers
    localparam logic [3:0] FidSignature = 4'd0;
    localparam logic [3:0] FidVersion   = 4'd1;
    localparam logic [3:0] FidFlags     = 4'd2;
    localparam logic [3:0] FidCrc       = 4'd6;
    localparam logic [3:0] FidCsize     = 4'd7;
    localparam logic [3:0] FidUsize     = 4'd8;
    localparam logic [3:0] FidNameLen   = 4'd9;
    localparam logic [3:0] FidExtraLen  = 4'd10;
    // descriptor fields run 0..2
    localparam logic [3:0] FidDescLast  = 4'd2;

    typedef enum logic [2:0] {
        KIND_HDR_FIELD  = 3'd0,
        KIND_NAME_BYTE  = 3'd1,
        KIND_EXTRA_BYTE = 3'd2,
        KIND_DATA_BYTE  = 3'd3,
        KIND_DESC_FIELD = 3'd4,
        KIND_UNKNOWN    = 3'd5,
        KIND_SKIP       = 3'd6
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } zlh_item_t;

    typedef struct packed {
        kind_t                  kind;
        logic [3:0]             field_id;
        logic [31:0]            value;
        logic [OffsetWidth-1:0] offset;
        logic [15:0]            record_number;
        logic                   last_of_run;
    } zlh_result_t;

    // handshake between the parser and the result queue
    typedef struct packed {
        logic push;
        logic full;
    } zlh_queue_ctl_t;

endpackage

@@ hdl/zlh_parser.sv @@
module zlh_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_pass,
    input  logic                item_valid,
    input  zlh_pkg::zlh_item_t  item,
    input  logic                queue_full,
    output logic                item_consume,
    output logic                res_push,
    output zlh_pkg::zlh_result_t res
);
    import zlh_pkg::*;

    typedef enum logic [3:0] {
        PH_SIG, PH_HDR, PH_NAME, PH_EXTRA, PH_DATA, PH_DESC, PH_HUNT
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             fbc_reg, fbc_next;
    logic [3:0]             fidx_reg, fidx_next;
    logic [31:0]            asm_reg, asm_next;
    logic [31:0]            remain_reg, remain_next;
    logic [15:0]            name_len_reg, name_len_next;
    logic [15:0]            extra_len_reg, extra_len_next;
    logic [31:0]            data_len_reg, data_len_next;
    logic                   desc_reg, desc_next;
    logic                   pend_reg, pend_next;
    logic [31:0]            skip_reg, skip_next;
    logic [OffsetWidth-1:0] skip_start_reg, skip_start_next;
    logic [OffsetWidth-1:0] pos_reg, pos_next;
    logic [15:0]            hcount_reg, hcount_next;
    logic                   pass_reg;

    logic [OffsetWidth-1:0] pos_inc;
    logic [31:0]            shifted;
    logic                   gather_done;
    logic                   go_name, go_extra, go_data, go_after, go_hunt;
    logic                   emit;
    zlh_result_t            res_c;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == SkipMax) ? v : v + 32'd1;
    endfunction

    assign item_consume = item_valid && !queue_full;
    assign pos_inc      = pos_reg + {{(OffsetWidth-1){1'b0}}, 1'b1};
    assign shifted      = asm_reg | ({24'd0, item.in_byte} << {fbc_reg, 3'b000});

    always_comb begin
        phase_next      = phase_reg;
        fbc_next        = fbc_reg;
        fidx_next       = fidx_reg;
        asm_next        = asm_reg;
        remain_next     = remain_reg;
        name_len_next   = name_len_reg;
        extra_len_next  = extra_len_reg;
        data_len_next   = data_len_reg;
        desc_next       = desc_reg;
        pend_next       = pend_reg;
        skip_next       = skip_reg;
        skip_start_next = skip_start_reg;
        pos_next        = pos_inc;
        hcount_next     = hcount_reg;
        go_name         = 1'b0;
        go_extra        = 1'b0;
        go_data         = 1'b0;
        go_after        = 1'b0;
        go_hunt         = 1'b0;
        gather_done     = 1'b0;
        emit            = 1'b0;
        res_c           = '0;
        res_c.kind      = KIND_HDR_FIELD;

        case (phase_reg)
            PH_SIG: begin
                gather_done = (fbc_reg == 2'd3);
                if (gather_done) begin
                    fbc_next = '0;
                    asm_next = '0;
                    emit = 1'b1;
                    res_c.value  = shifted;
                    res_c.offset = pos_reg - OffsetWidth'(3);
                    if (shifted == LocalSig) begin
                        if (hcount_reg != RecordMax) hcount_next = hcount_reg + 16'd1;
                        res_c.kind     = KIND_HDR_FIELD;
                        res_c.field_id = FidSignature;
                        phase_next     = PH_HDR;
                        fidx_next      = FidVersion;
                    end else begin
                        res_c.kind = KIND_UNKNOWN;
                        go_hunt    = 1'b1;
                    end
                end else begin
                    fbc_next = fbc_reg + 2'd1;
                    asm_next = shifted;
                end
            end
            PH_HDR: begin
                if (fidx_reg inside {[FidCrc:FidUsize]}) begin
                    gather_done  = (fbc_reg == 2'd3);
                    res_c.offset = pos_reg - OffsetWidth'(3);
                end else begin
                    gather_done  = (fbc_reg != 2'd0);
                    res_c.offset = pos_reg - OffsetWidth'(1);
                end
                if (gather_done) begin
                    fbc_next = '0;
                    asm_next = '0;
                    emit = 1'b1;
                    res_c.kind     = KIND_HDR_FIELD;
                    res_c.field_id = fidx_reg;
                    res_c.value    = shifted;
                    if (fidx_reg == FidFlags) desc_next = |(shifted[15:0] & DescBit);
                    if (fidx_reg == FidCsize) data_len_next = shifted;
                    if (fidx_reg == FidNameLen) name_len_next = shifted[15:0];
                    if (fidx_reg >= FidExtraLen) begin
                        extra_len_next = shifted[15:0];
                        fidx_next = '0;
                        go_name = 1'b1;
                    end else begin
                        fidx_next = fidx_reg + 4'd1;
                    end
                end else begin
                    fbc_next = fbc_reg + 2'd1;
                    asm_next = shifted;
                end
            end
            PH_NAME, PH_EXTRA, PH_DATA: begin
                res_c.value  = {24'd0, item.in_byte};
                res_c.offset = pos_reg;
                if (phase_reg == PH_NAME) begin
                    emit = 1'b1;
                    res_c.kind = KIND_NAME_BYTE;
                end else if (phase_reg == PH_EXTRA) begin
                    emit = 1'b1;
                    res_c.kind = KIND_EXTRA_BYTE;
                end else begin
                    emit = pass_reg;
                    res_c.kind = KIND_DATA_BYTE;
                end
                remain_next = remain_reg - 32'd1;
                if (remain_reg == 32'd1) begin
                    if (phase_reg == PH_NAME) go_extra = 1'b1;
                    else if (phase_reg == PH_EXTRA) go_data = 1'b1;
                    else go_after = 1'b1;
                end
            end
            PH_DESC: begin
                gather_done = (fbc_reg == 2'd3);
                if (gather_done) begin
                    fbc_next = '0;
                    asm_next = '0;
                    emit = 1'b1;
                    res_c.kind     = KIND_DESC_FIELD;
                    res_c.field_id = fidx_reg;
                    res_c.value    = shifted;
                    res_c.offset   = pos_reg - OffsetWidth'(3);
                    if (fidx_reg >= FidDescLast) begin
                        fidx_next = '0;
                        go_hunt = 1'b1;
                    end else begin
                        fidx_next = fidx_reg + 4'd1;
                    end
                end else begin
                    fbc_next = fbc_reg + 2'd1;
                    asm_next = shifted;
                end
            end
            default: begin
                if (pend_reg && item.in_byte == CharK) begin
                    emit         = (skip_reg != '0);
                    res_c.kind   = KIND_SKIP;
                    res_c.value  = skip_reg;
                    res_c.offset = skip_start_reg;
                    skip_next    = '0;
                    pend_next    = 1'b0;
                    phase_next   = PH_SIG;
                    asm_next     = {16'd0, CharK, CharP};
                    fbc_next     = 2'd2;
                end else begin
                    // a held 'P' without its 'K' counts as skipped
                    skip_next = pend_reg ? sat_inc(skip_reg) : skip_reg;
                    if (item.in_byte == CharP) begin
                        pend_next = 1'b1;
                    end else begin
                        pend_next = 1'b0;
                        skip_next = sat_inc(skip_next);
                    end
                end
            end
        endcase

        // walk past empty name, extra and data sections
        if (go_name) begin
            phase_next  = PH_NAME;
            remain_next = {16'd0, name_len_next};
            go_extra    = (name_len_next == '0);
        end
        if (go_extra) begin
            phase_next  = PH_EXTRA;
            remain_next = {16'd0, extra_len_next};
            go_data     = (extra_len_next == '0);
        end
        if (go_data) begin
            phase_next  = PH_DATA;
            remain_next = data_len_next;
            go_after    = (data_len_next == '0);
        end
        if (go_after) begin
            if (desc_next) begin
                phase_next = PH_DESC;
                fidx_next  = '0;
                fbc_next   = '0;
                asm_next   = '0;
            end else begin
                go_hunt = 1'b1;
            end
        end
        if (go_hunt) begin
            phase_next      = PH_HUNT;
            skip_next       = '0;
            pend_next       = 1'b0;
            skip_start_next = pos_inc;
        end

        if (item.end_of_stream && phase_next == PH_HUNT) begin
            if (pend_next) skip_next = sat_inc(skip_next);
            if (skip_next != '0) begin
                emit           = 1'b1;
                res_c.kind     = KIND_SKIP;
                res_c.field_id = '0;
                res_c.value    = skip_next;
                res_c.offset   = skip_start_next;
            end
        end

        res_c.record_number = hcount_next;
        res_c.last_of_run   = 1'b1;

        // end of archive: start over at position zero
        if (item.end_of_stream) begin
            phase_next      = PH_SIG;
            fbc_next        = '0;
            fidx_next       = '0;
            asm_next        = '0;
            remain_next     = '0;
            name_len_next   = '0;
            extra_len_next  = '0;
            data_len_next   = '0;
            desc_next       = 1'b0;
            pend_next       = 1'b0;
            skip_next       = '0;
            skip_start_next = '0;
            pos_next        = '0;
            hcount_next     = '0;
        end
    end

    assign res_push = item_consume && emit;
    assign res      = res_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SIG;
            fbc_reg        <= '0;
            fidx_reg       <= '0;
            asm_reg        <= '0;
            remain_reg     <= '0;
            name_len_reg   <= '0;
            extra_len_reg  <= '0;
            data_len_reg   <= '0;
            desc_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            skip_reg       <= '0;
            skip_start_reg <= '0;
            pos_reg        <= '0;
            hcount_reg     <= '0;
            pass_reg       <= 1'b0;
        end else begin
            if (cfg_we) pass_reg <= cfg_pass;
            if (item_consume) begin
                phase_reg      <= phase_next;
                fbc_reg        <= fbc_next;
                fidx_reg       <= fidx_next;
                asm_reg        <= asm_next;
                remain_reg     <= remain_next;
                name_len_reg   <= name_len_next;
                extra_len_reg  <= extra_len_next;
                data_len_reg   <= data_len_next;
                desc_reg       <= desc_next;
                pend_reg       <= pend_next;
                skip_reg       <= skip_next;
                skip_start_reg <= skip_start_next;
                pos_reg        <= pos_next;
                hcount_reg     <= hcount_next;
            end
        end
    end

    a_skip_only_hunting: assert property (@(posedge aclk) disable iff (!aresetn)
        (skip_reg != '0 || pend_reg) |-> phase_reg == PH_HUNT)
        else $error("skip count or held P outside the hunt");

    a_hdr_index: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HDR |-> (fidx_reg >= FidVersion && fidx_reg <= FidExtraLen))
        else $error("header field index out of range");

    a_body_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_NAME || phase_reg == PH_EXTRA || phase_reg == PH_DATA)
            |-> remain_reg != '0)
        else $error("body section entered with nothing left");

    a_pos_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_consume && !item.end_of_stream) |=> pos_reg == $past(pos_inc))
        else $error("stream position did not advance");

endmodule

@@ hdl/zlh_out_queue.sv @@
module zlh_out_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  zlh_pkg::zlh_queue_ctl_t ctl_in,
    input  zlh_pkg::zlh_result_t  push_data,
    output logic                  full,
    output logic                  head_valid,
    input  logic                  head_ready,
    output zlh_pkg::zlh_result_t  head
);
    import zlh_pkg::*;

    zlh_result_t ent0_reg, ent0_next;
    zlh_result_t ent1_reg, ent1_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    assign head_valid = (cnt_reg != 2'd0);
    assign full       = (cnt_reg == 2'd2);
    assign head       = ent0_reg;
    assign pop        = head_valid && head_ready;

    always_comb begin
        ent0_next = ent0_reg;
        ent1_next = ent1_reg;
        cnt_next  = cnt_reg;
        case ({ctl_in.push, pop})
            2'b10: begin
                if (cnt_reg == 2'd0) ent0_next = push_data;
                else ent1_next = push_data;
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01: begin
                ent0_next = ent1_reg;
                cnt_next  = cnt_reg - 2'd1;
            end
            2'b11: begin
                if (cnt_reg == 2'd1) begin
                    ent0_next = push_data;
                end else begin
                    ent0_next = ent1_reg;
                    ent1_next = push_data;
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_in.full |-> !ctl_in.push)
        else $error("push into a full result queue");

    a_hold_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid && !head_ready) |=> (head_valid && head == $past(head)))
        else $error("waiting result changed");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result queue count corrupt");

endmodule

@@ hdl/zip_local_header_stream_parser_core.sv @@
// Channel   Direction  Transaction contents
// s_        in         tdata[7:0] archive byte, tlast end of archive
// m_        out        tdata field/value/offset/record, tuser kind, tlast end of run
// cfg_      in         cfg_data = pass file data bytes (1) or count past them (0)
//
// One byte per cycle sustained while the result queue is not full. A byte is
// held in the input register, is parsed against the state registers and lands
// in a two-entry result queue; a byte gives at most one result. s_tready stays
// high while the result queue has room, so a waiting result does not stall
// input until two are queued. Reset is synchronous on aresetn; the data-pass
// register resets to 0 (count past data).
module zip_local_header_stream_parser_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] in_byte
    input  logic         s_tlast,   // end_of_stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [3:0] field_id, [35:4] value, [83:36] offset,
                                    // [99:84] record_number, [103:100] zero
    output logic [2:0]   m_tuser,   // [2:0] kind
    output logic         m_tlast,   // last_of_run
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data   // pass_data_bytes
);
    import zlh_pkg::*;

    logic           in_valid_reg;
    zlh_item_t      in_item_reg;
    logic           consume;
    logic           queue_full;
    logic           push;
    zlh_result_t    push_data;
    zlh_result_t    head;
    zlh_queue_ctl_t qctl;

    assign cfg_ready = 1'b1;
    assign s_tready  = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_item_reg.in_byte       <= s_tdata;
            in_item_reg.end_of_stream <= s_tlast;
        end
    end

    zlh_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_pass     (cfg_data),
        .item_valid   (in_valid_reg),
        .item         (in_item_reg),
        .queue_full   (queue_full),
        .item_consume (consume),
        .res_push     (push),
        .res          (push_data)
    );

    assign qctl.push = push;
    assign qctl.full = queue_full;

    zlh_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl_in     (qctl),
        .push_data  (push_data),
        .full       (queue_full),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    assign m_tdata = {4'd0, head.record_number, head.offset, head.value, head.field_id};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

endmodule
